// ===== rtl/core/mpt_pkg.sv =====
// Shared types, codes and constants of the memory pattern test engine.
`timescale 1ns / 1ps

package mpt_pkg;

    localparam int WORD_W      = 32;
    localparam int COUNT_W     = 25;
    localparam int ROUNDS_W    = 8;
    localparam int PASSES_W    = 16;
    localparam int PAT_W       = 3;
    localparam int ROUND_W     = 16;
    localparam int CFG_INDEX_W = 3;

    localparam int INDEX_WIDTH_DEF = 24;

    // Register indexes on the configuration channel.
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WORD_COUNT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROUNDS        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TEST_MODE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_PASSES   = 3'd4;

    localparam logic [WORD_W-1:0]   BASE_ADDRESS_RST = 32'h1000_0000;
    localparam logic [COUNT_W-1:0]  WORD_COUNT_RST   = 25'd786432;
    localparam logic [ROUNDS_W-1:0] ROUNDS_RST       = 8'd3;
    localparam logic                TEST_MODE_RST    = 1'b0;
    localparam logic [PASSES_W-1:0] HOLD_PASSES_RST  = 16'd30;

    // Pattern numbers and pattern constants.
    localparam logic [PAT_W-1:0] PAT_ZERO     = 3'd0;
    localparam logic [PAT_W-1:0] PAT_ONES     = 3'd1;
    localparam logic [PAT_W-1:0] PAT_ALT      = 3'd2;
    localparam logic [PAT_W-1:0] PAT_HALF     = 3'd3;
    localparam logic [PAT_W-1:0] HOLD_PATTERN = 3'd4;
    localparam logic [PAT_W-1:0] LAST_PATTERN = 3'd5;

    localparam logic [WORD_W-1:0] WORD_ONES = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_ALT  = 32'hAAAA_AAAA;
    localparam logic [WORD_W-1:0] WORD_HALF = 32'h5555_AAAA;
    localparam logic [WORD_W-1:0] ADDR_KEY  = 32'hA5A5_A5A5;
    localparam logic [WORD_W-1:0] INDEX_KEY = 32'h1357_9BDF;
    localparam int                INDEX_SHIFT = 7;

    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_PASS  = 2'd2,
        OP_FAIL  = 2'd3
    } op_t;

    localparam logic FUNC_START = 1'b0;

    typedef struct packed {
        op_t                op;
        logic [WORD_W-1:0]  address;
        logic [WORD_W-1:0]  data_word;
        logic [WORD_W-1:0]  actual_word;
        logic [PAT_W-1:0]   pattern_used;
        logic [ROUND_W-1:0] round_used;
        logic               test_done;
    } result_t;

endpackage

// ===== rtl/core/mpt_if.sv =====
// Channel interfaces: command input, result output and configuration writes.
`timescale 1ns / 1ps

interface mpt_req_if import mpt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [WORD_W-1:0] read_word;

    modport source (output valid, output func, output read_word, input ready);
    modport sink   (input valid, input func, input read_word, output ready);
endinterface

interface mpt_rsp_if import mpt_pkg::*; ();
    logic               valid;
    logic               ready;
    op_t                op;
    logic [WORD_W-1:0]  address;
    logic [WORD_W-1:0]  data_word;
    logic [WORD_W-1:0]  actual_word;
    logic [PAT_W-1:0]   pattern_used;
    logic [ROUND_W-1:0] round_used;
    logic               test_done;

    modport source (output valid, output op, output address, output data_word,
                    output actual_word, output pattern_used, output round_used,
                    output test_done, input ready);
    modport sink   (input valid, input op, input address, input data_word,
                    input actual_word, input pattern_used, input round_used,
                    input test_done, output ready);
endinterface

interface mpt_cfg_if import mpt_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [WORD_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/mpt_word_gen.sv =====
// Address and pattern word generator for one word index.
`timescale 1ns / 1ps

module mpt_word_gen import mpt_pkg::*; #(
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
    input  logic [WORD_W-1:0]      base,
    input  logic [INDEX_WIDTH-1:0] idx,
    input  logic [PAT_W-1:0]       pattern,
    output logic [WORD_W-1:0]      address,
    output logic [WORD_W-1:0]      data_word
);

    logic [WORD_W-1:0] idx_word;
    logic [WORD_W-1:0] offset;

    assign idx_word = WORD_W'(idx);
    assign offset   = {idx_word[WORD_W-3:0], 2'b00};
    // The two low bits of the base are ignored; the sum wraps at 32 bits.
    assign address  = {base[WORD_W-1:2], 2'b00} + offset;

    always_comb
    begin
        unique case (pattern)
            PAT_ZERO:     data_word = '0;
            PAT_ONES:     data_word = WORD_ONES;
            PAT_ALT:      data_word = WORD_ALT;
            PAT_HALF:     data_word = WORD_HALF;
            HOLD_PATTERN: data_word = address ^ ADDR_KEY;
            default:      data_word = idx_word ^ (idx_word << INDEX_SHIFT) ^ INDEX_KEY;
        endcase
    end

endmodule

// ===== rtl/core/memory_pattern_test_engine.sv =====
// Memory pattern test engine: top level with sequencer and result register.
`timescale 1ns / 1ps
//
// Usage: write the configuration registers over the cfg channel (always
// ready, one write per beat), then send a start beat (func 0) on req.
// Each following req beat with func 1 is one memory beat: in a write pass
// the engine answers with a write command (address and data), in a check
// pass it compares read_word against the expected word and answers pass or
// failure. Every req beat produces exactly one rsp beat; idle beats and the
// start beat answer with an all-zero result.
// Latency: the result of a req beat is on rsp in the cycle after it is
// accepted. Throughput: one beat per cycle unless rsp stalls; the
// sequencer state, address adder and compare sit between the req port
// and the result register. The result register parts the two sides:
// req stays ready while the result register is empty or being taken, so
// a stalled rsp holds one result and then stalls req.
// Reset clears the sequencer (no test running), empties the result
// register and loads the default register values.
//
module memory_pattern_test_engine import mpt_pkg::*; #(
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    mpt_req_if.sink   req,
    mpt_rsp_if.source rsp,
    mpt_cfg_if.sink   cfg
);

    localparam int CNT_W = (INDEX_WIDTH + 1 > COUNT_W) ? INDEX_WIDTH + 1 : COUNT_W;

    // Configuration registers.
    logic [WORD_W-1:0]   base_address_reg;
    logic [COUNT_W-1:0]  word_count_reg;
    logic [ROUNDS_W-1:0] rounds_reg;
    logic                test_mode_reg;
    logic [PASSES_W-1:0] hold_passes_reg;

    // Sequencer state.
    logic                   running_reg,  running_next;
    logic                   check_reg,    check_next;
    logic                   hold_reg,     hold_next;
    logic [PAT_W-1:0]       pattern_reg,  pattern_next;
    logic [ROUND_W-1:0]     round_reg,    round_next;
    logic [INDEX_WIDTH-1:0] index_reg,    index_next;

    logic    out_valid_reg, out_valid_next;
    result_t res_reg, res_next;

    logic                accept;
    logic                last_word;
    logic [CNT_W-1:0]    idx_inc;
    logic [CNT_W-1:0]    count_eff;
    logic [ROUNDS_W-1:0] rounds_eff;
    logic [PASSES_W-1:0] passes_eff;
    logic [WORD_W-1:0]   gen_address;
    logic [WORD_W-1:0]   gen_data;

    assign cfg.ready = 1'b1;
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= BASE_ADDRESS_RST;
            word_count_reg   <= WORD_COUNT_RST;
            rounds_reg       <= ROUNDS_RST;
            test_mode_reg    <= TEST_MODE_RST;
            hold_passes_reg  <= HOLD_PASSES_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_BASE_ADDRESS: base_address_reg <= cfg.data;
                REG_WORD_COUNT:   word_count_reg   <= cfg.data[COUNT_W-1:0];
                REG_ROUNDS:       rounds_reg       <= cfg.data[ROUNDS_W-1:0];
                REG_TEST_MODE:    test_mode_reg    <= cfg.data[0];
                REG_HOLD_PASSES:  hold_passes_reg  <= cfg.data[PASSES_W-1:0];
                default:          ;
            endcase
        end
    end

    mpt_word_gen #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_word_gen (
        .base      (base_address_reg),
        .idx       (index_reg),
        .pattern   (pattern_reg),
        .address   (gen_address),
        .data_word (gen_data)
    );

    // Zero counts act as one; a count beyond the index range is capped by
    // treating the all-ones index as the last word.
    assign count_eff  = (word_count_reg == '0) ? CNT_W'(1) : CNT_W'(word_count_reg);
    assign rounds_eff = (rounds_reg == '0) ? ROUNDS_W'(1) : rounds_reg;
    assign passes_eff = (hold_passes_reg == '0) ? PASSES_W'(1) : hold_passes_reg;
    assign idx_inc    = CNT_W'(index_reg) + CNT_W'(1);
    assign last_word  = (idx_inc >= count_eff) || (&index_reg);

    always_comb
    begin
        running_next = running_reg;
        check_next   = check_reg;
        hold_next    = hold_reg;
        pattern_next = pattern_reg;
        round_next   = round_reg;
        index_next   = index_reg;
        res_next     = '0;
        res_next.op  = OP_IDLE;

        if (accept)
        begin
            if (req.func == FUNC_START)
            begin
                running_next = 1'b1;
                check_next   = 1'b0;
                hold_next    = test_mode_reg;
                pattern_next = test_mode_reg ? HOLD_PATTERN : PAT_ZERO;
                round_next   = '0;
                index_next   = '0;
            end
            else if (running_reg)
            begin
                res_next.address      = gen_address;
                res_next.data_word    = gen_data;
                res_next.pattern_used = pattern_reg;
                res_next.round_used   = round_reg;
                if (!check_reg)
                begin
                    res_next.op = OP_WRITE;
                    if (last_word)
                    begin
                        index_next = '0;
                        check_next = 1'b1;
                        if (hold_reg)
                        begin
                            round_next = ROUND_W'(1);
                        end
                    end
                    else
                    begin
                        index_next = index_reg + INDEX_WIDTH'(1);
                    end
                end
                else
                begin
                    res_next.actual_word = req.read_word;
                    if (req.read_word != gen_data)
                    begin
                        res_next.op        = OP_FAIL;
                        res_next.test_done = 1'b1;
                        running_next       = 1'b0;
                    end
                    else
                    begin
                        res_next.op = OP_PASS;
                        if (!last_word)
                        begin
                            index_next = index_reg + INDEX_WIDTH'(1);
                        end
                        else
                        begin
                            index_next = '0;
                            if (hold_reg)
                            begin
                                if (round_reg >= passes_eff)
                                begin
                                    res_next.test_done = 1'b1;
                                    running_next       = 1'b0;
                                end
                                else
                                begin
                                    round_next = round_reg + ROUND_W'(1);
                                end
                            end
                            else
                            begin
                                check_next = 1'b0;
                                if (({1'b0, round_reg} + 17'd1) < 17'(rounds_eff))
                                begin
                                    round_next = round_reg + ROUND_W'(1);
                                end
                                else if (pattern_reg < LAST_PATTERN)
                                begin
                                    pattern_next = pattern_reg + PAT_W'(1);
                                    round_next   = '0;
                                end
                                else
                                begin
                                    res_next.test_done = 1'b1;
                                    running_next       = 1'b0;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    assign out_valid_next = accept ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            check_reg     <= 1'b0;
            hold_reg      <= 1'b0;
            pattern_reg   <= '0;
            round_reg     <= '0;
            index_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            running_reg   <= running_next;
            check_reg     <= check_next;
            hold_reg      <= hold_next;
            pattern_reg   <= pattern_next;
            round_reg     <= round_next;
            index_reg     <= index_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.op           = res_reg.op;
    assign rsp.address      = res_reg.address;
    assign rsp.data_word    = res_reg.data_word;
    assign rsp.actual_word  = res_reg.actual_word;
    assign rsp.pattern_used = res_reg.pattern_used;
    assign rsp.round_used   = res_reg.round_used;
    assign rsp.test_done    = res_reg.test_done;

    // The pattern counter never runs past the last pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        pattern_reg <= LAST_PATTERN)
        else $error("pattern number beyond the last pattern");

    // A hold test only ever uses the hold pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        (running_reg && hold_reg) |-> (pattern_reg == HOLD_PATTERN))
        else $error("hold test left the hold pattern");

    // A mismatch always ends the test.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.op == OP_FAIL) |-> res_reg.test_done)
        else $error("failure beat without test end");

    // A beat that ends the test leaves the sequencer stopped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_next.test_done) |=> !running_reg)
        else $error("sequencer still running after test end");

endmodule
